>>> hdl/brs_pkg.sv
// Shared types and constants of the block request segmenter.
`timescale 1ns / 1ps

package brs_pkg;

   // Payload widths, fixed by the transaction formats
   localparam int OpW       = 1;
   localparam int BlockW    = 32;
   localparam int OffsetW   = 30;
   localparam int LenW      = 20;
   localparam int AddrOutW  = 62;
   localparam int IoW       = LenW + 1;

   // Configuration register port
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 5;
   localparam int SectorW   = 4;
   localparam int FragW     = 5;
   localparam int BlkLogW   = 5;

   localparam logic [CsrIndexW-1:0] RegSectorLog2 = 2'd0;
   localparam logic [CsrIndexW-1:0] RegFragLog2   = 2'd1;
   localparam logic [CsrIndexW-1:0] RegBlockLog2  = 2'd2;

   // Reset values and legal ranges of the size registers
   localparam logic [SectorW-1:0] SectorReset = 4'd9;
   localparam logic [SectorW-1:0] SectorMin   = 4'd9;
   localparam logic [SectorW-1:0] SectorMax   = 4'd14;
   localparam logic [FragW-1:0]   FragReset   = 5'd14;
   localparam logic [FragW-1:0]   FragMin     = 5'd14;
   localparam logic [FragW-1:0]   FragMax     = 5'd22;
   localparam logic [BlkLogW-1:0] BlockReset  = 5'd22;
   localparam logic [BlkLogW-1:0] BlockMin    = 5'd19;
   localparam logic [BlkLogW-1:0] BlockMax    = 5'd30;

   // Sector and fragment sizes at their largest
   localparam int SectorSizeW = 15;
   localparam int SectorMaskW = 14;
   localparam int FragSizeW   = 23;

   // Segments per request at most
   localparam int SegLimit = 36;
   localparam int CountW   = $clog2(SegLimit);
   localparam logic [CountW-1:0] CountLast = CountW'(SegLimit - 1);

   typedef struct packed {
      logic [OpW-1:0]     operation;
      logic [BlockW-1:0]  block_number;
      logic [OffsetW-1:0] offset;
      logic [LenW-1:0]    length;
   } brs_req_type;

   typedef struct packed {
      logic [AddrOutW-1:0] aligned_address;
      logic [LenW-1:0]     io_length;
      logic [AddrOutW-1:0] data_address;
      logic [LenW-1:0]     data_length;
      logic                needs_merge;
      logic                last_segment;
   } brs_rsp_type;

   typedef enum logic [1:0] {
      BRS_IDLE,
      BRS_LOAD,
      BRS_RUN
   } brs_state_type;

   typedef struct packed {
      logic capture;   // latch the request transaction
      logic start;     // form start address and saturated length
      logic step;      // emit one segment into the output register
   } brs_cmd_type;

   typedef struct packed {
      logic len_zero;  // captured request has no data
      logic out_free;  // output register can take a segment this cycle
      logic seg_last;  // segment being formed ends the request
   } brs_status_type;

endpackage

>>> hdl/brs_ctrl.sv
// Controller state machine of the block request segmenter.
`timescale 1ns / 1ps

module brs_ctrl
   import brs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  brs_status_type status,
   output brs_cmd_type    cmd
);

   brs_state_type state_ff;
   brs_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BRS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         BRS_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = BRS_LOAD;
            end
         end
         BRS_LOAD: begin
            cmd.start = 1'b1;
            state_in  = status.len_zero ? BRS_IDLE : BRS_RUN;
         end
         BRS_RUN: begin
            if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.seg_last) begin
                  state_in = BRS_IDLE;
               end
            end
         end
         default: begin
            state_in = BRS_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/brs_datapath.sv
// Datapath of the block request segmenter: size registers, walk registers, segment former.
`timescale 1ns / 1ps

module brs_datapath
   import brs_pkg::*;
#(
   parameter int MAX_LENGTH_LOG2 = 19,
   parameter int ADDRESS_WIDTH   = 62
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  brs_req_type          req_data,
   output brs_rsp_type          rsp_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 csr_write,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata,
   input  brs_cmd_type          cmd,
   output brs_status_type       status
);

   localparam int CmpW = (MAX_LENGTH_LOG2 + 1 > LenW) ? MAX_LENGTH_LOG2 + 1 : LenW;
   localparam logic [CmpW-1:0] MaxLen = CmpW'(1) << MAX_LENGTH_LOG2;

   // Size registers
   logic [SectorW-1:0] sector_log2_ff, sector_log2_in;
   logic [FragW-1:0]   frag_log2_ff,   frag_log2_in;
   logic [BlkLogW-1:0] block_log2_ff,  block_log2_in;

   // Walk registers
   brs_req_type              req_ff,   req_in;
   logic [ADDRESS_WIDTH-1:0] addr_ff,  addr_in;
   logic [LenW-1:0]          rem_ff,   rem_in;
   logic [CountW-1:0]        count_ff, count_in;
   brs_rsp_type              rsp_ff,   rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Clamped sizes
   logic [SectorW-1:0]     sl;
   logic [FragW-1:0]       fl;
   logic [BlkLogW-1:0]     bl;
   logic [SectorSizeW-1:0] ssz;
   logic [SectorMaskW-1:0] smask;
   logic [FragSizeW-1:0]   fsz;

   // Segment former
   logic [SectorMaskW-1:0] head;
   logic [SectorSizeW-1:0] head_room;
   logic [IoW-1:0]         io_round;
   logic [IoW-1:0]         seg_io;
   logic [LenW-1:0]        seg_dl;
   logic [LenW-1:0]        rem_next;
   logic [63:0]            start_sum;
   brs_rsp_type            seg;

   always_comb begin
      sl = (sector_log2_ff < SectorMin) ? SectorMin :
           (sector_log2_ff > SectorMax) ? SectorMax : sector_log2_ff;
      fl = (frag_log2_ff < FragMin) ? FragMin :
           (frag_log2_ff > FragMax) ? FragMax : frag_log2_ff;
      bl = (block_log2_ff < BlockMin) ? BlockMin :
           (block_log2_ff > BlockMax) ? BlockMax : block_log2_ff;
      ssz   = SectorSizeW'(1) << sl;
      smask = SectorMaskW'(ssz - SectorSizeW'(1));
      fsz   = FragSizeW'(1) << fl;
   end

   // One segment from the current walk position
   always_comb begin
      head      = smask & addr_ff[SectorMaskW-1:0];
      head_room = ssz - SectorSizeW'(head);
      io_round  = '0;
      if (head != '0) begin
         // unaligned head: one full sector, read-merge
         seg_dl = (LenW'(head_room) > rem_ff) ? rem_ff : LenW'(head_room);
         seg_io = IoW'(ssz);
      end else begin
         seg_dl   = (FragSizeW'(rem_ff) < fsz) ? rem_ff : LenW'(fsz);
         io_round = (IoW'(seg_dl) + IoW'(smask)) & ~IoW'(smask);
         seg_io   = io_round;
         // write: drop the partial tail sector so it merges later
         if (req_ff.operation == 1'b1 && io_round != IoW'(seg_dl) &&
             io_round > IoW'(ssz)) begin
            seg_io = io_round - IoW'(ssz);
            seg_dl = seg_io[LenW-1:0];
         end
      end
      rem_next = rem_ff - seg_dl;

      seg.aligned_address = AddrOutW'(addr_ff & ~ADDRESS_WIDTH'(smask));
      seg.io_length       = seg_io[LenW-1:0];
      seg.data_address    = AddrOutW'(addr_ff);
      seg.data_length     = seg_dl;
      seg.needs_merge     = (seg_io != IoW'(seg_dl));
      seg.last_segment    = (rem_next == '0) || (count_ff == CountLast);
   end

   always_comb begin
      sector_log2_in = sector_log2_ff;
      frag_log2_in   = frag_log2_ff;
      block_log2_in  = block_log2_ff;
      if (csr_write) begin
         case (csr_index)
            RegSectorLog2: sector_log2_in = csr_wdata[SectorW-1:0];
            RegFragLog2:   frag_log2_in   = csr_wdata[FragW-1:0];
            RegBlockLog2:  block_log2_in  = csr_wdata[BlkLogW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      req_in       = req_ff;
      addr_in      = addr_ff;
      rem_in       = rem_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      start_sum    = (64'(req_ff.block_number) << bl) + 64'(req_ff.offset);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.capture) begin
         req_in = req_data;
      end
      if (cmd.start) begin
         addr_in  = ADDRESS_WIDTH'(start_sum);
         rem_in   = (CmpW'(req_ff.length) > MaxLen) ? LenW'(MaxLen) : req_ff.length;
         count_in = '0;
      end
      if (cmd.step) begin
         rsp_in       = seg;
         rsp_valid_in = 1'b1;
         addr_in      = addr_ff + ADDRESS_WIDTH'(seg_dl);
         rem_in       = rem_next;
         count_in     = count_ff + CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_log2_ff <= SectorReset;
         frag_log2_ff   <= FragReset;
         block_log2_ff  <= BlockReset;
         rsp_valid_ff   <= 1'b0;
         count_ff       <= '0;
      end else begin
         sector_log2_ff <= sector_log2_in;
         frag_log2_ff   <= frag_log2_in;
         block_log2_ff  <= block_log2_in;
         rsp_valid_ff   <= rsp_valid_in;
         count_ff       <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      addr_ff <= addr_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data        = rsp_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign status.len_zero = (req_ff.length == '0);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.seg_last = seg.last_segment;

endmodule

>>> hdl/block_request_segmenter_top.sv
// Top level of the block request segmenter: controller and datapath.
`timescale 1ns / 1ps

// Splits one read or write request on a file system block into device
// segments, in address order. The request starts at device byte address
// block_number * 2^block_size_log2 + offset (wrapping at ADDRESS_WIDTH bits).
// An unaligned start yields one sector-sized read-merge segment for the head;
// aligned parts are cut at the fragment size and rounded up to whole sectors,
// and on writes a rounded part longer than one sector is shortened to whole
// sectors so that its tail becomes a later merge segment. needs_merge marks a
// segment whose io_length differs from its data_length; last_segment marks the
// final one. A request longer than 2^MAX_LENGTH_LOG2 bytes is saturated to it,
// a zero-length request yields no segment, and a request is cut off after 36
// segments (the 36th then carries last_segment). Size registers out of range
// are clamped (sector 9..14, fragment 14..22, block 19..30); write them only
// while no request is in flight. Setup of a request transaction captures it and
// then forms the start address (shift and add); segments follow at one per cycle
// from the single segment former whenever the result side does not stall. The
// last segment may still wait in the output register while the next request
// transaction is taken.
module block_request_segmenter_top
   import brs_pkg::*;
#(
   parameter int MAX_LENGTH_LOG2 = 19,
   parameter int ADDRESS_WIDTH   = 62
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  brs_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output brs_rsp_type          rsp_data,
   input  logic                 csr_write,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata
);

   brs_cmd_type    cmd;     // controller commands to the datapath
   brs_status_type status;  // datapath conditions back to the controller

   // Sequence capture, start and one step per free output slot
   brs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the size registers, walk the request and register each segment
   brs_datapath #(
      .MAX_LENGTH_LOG2 (MAX_LENGTH_LOG2),
      .ADDRESS_WIDTH   (ADDRESS_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

>>> hdl/brs_checker.sv
// Port-level assertions of the block request segmenter and their binding.
`timescale 1ns / 1ps

module brs_checker
   import brs_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input brs_req_type          req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input brs_rsp_type          rsp_data,
   input logic                 csr_write,
   input logic [CsrIndexW-1:0] csr_index,
   input logic [CsrDataW-1:0]  csr_wdata
);

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result transaction changed");

   // a taken request blocks the next one for setup
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken during setup");

   // segments of one request follow without gaps once taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_segment |=> rsp_valid)
      else $error("gap inside a segment train");

   // no new request while a request is still being segmented
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_segment |-> req_stall)
      else $error("request taken mid-train");

   // merge flag matches the length difference
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.needs_merge == (rsp_data.io_length != rsp_data.data_length))
      else $error("merge flag inconsistent with lengths");

endmodule

bind block_request_segmenter_top brs_checker u_brs_checker (.*);
